>>> hw/rtl/tccw_pkg.sv
// Shared constants, types and register codes for the text console cursor writer.
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Special bytes and attributes
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Register select (paddr bit 2)
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // Item kinds
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Cell word: attribute in the high byte, character in the low byte
    typedef logic [CELL_W-1:0] t_cell_word;

    // Outcome of a put at the current cursor
    typedef struct packed {
        logic [ROW_W-1:0] row_nx;
        logic [COL_W-1:0] col_nx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_cell_word       wr_word;
        t_cell_word       cell0_word;
        logic             ovf;
    } t_put_res;

endpackage

`default_nettype wire

>>> hw/rtl/tccw_mem.sv
// Screen cell store: one write port, one registered read port.
`default_nettype none

module tccw_mem
    import tccw_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [IDX_W-1:0] i_waddr,
    input  t_cell_word       i_wdata,
    input  wire              i_re,
    input  wire  [IDX_W-1:0] i_raddr,
    output t_cell_word       o_rdata
);

    t_cell_word r_cells [0:CELLS-1];
    t_cell_word r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_cells[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered, loaded when i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_cells[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/tccw_cursor.sv
// Cursor update and cell write address for one put transaction.
`default_nettype none

module tccw_cursor
    import tccw_pkg::*;
(
    input  wire  [ROW_W-1:0]  i_row,
    input  wire  [COL_W-1:0]  i_col,
    input  wire  [CHAR_W-1:0] i_char,
    input  wire  [ATTR_W-1:0] i_attr,
    output t_put_res          o_res
);

    logic                 is_nl;
    logic                 is_bs;
    logic                 wrap;
    logic [ROW_W:0]       row_inc;
    logic                 row_over;
    logic [ROW_W-1:0]     row_w;
    logic [COL_W-1:0]     col_w;
    logic [IDX_W:0]       addr_full;
    logic [CHAR_W-1:0]    wr_char;

    always_comb begin
        is_nl    = (i_char == CHAR_NL);
        is_bs    = (i_char == CHAR_BS);
        wrap     = !is_nl && !is_bs && (i_col >= COL_W'(COLUMNS));
        row_inc  = {1'b0, i_row} + (ROW_W+1)'(1);
        row_over = (row_inc >= (ROW_W+1)'(ROWS));

        // Position the cell lands on
        row_w = i_row;
        col_w = i_col;
        if (wrap) begin
            row_w = row_inc[ROW_W-1:0];
            col_w = '0;
        end else if (is_bs && (i_col != '0)) begin
            col_w = i_col - COL_W'(1);
        end

        addr_full = (IDX_W+1)'(row_w) * (IDX_W+1)'(COLUMNS) + (IDX_W+1)'(col_w);
        wr_char   = is_bs ? CHAR_SPACE : i_char;

        o_res.ovf        = (is_nl || wrap) && row_over;
        o_res.wr_addr    = addr_full[IDX_W-1:0];
        o_res.wr_word    = {i_attr, wr_char};
        // After a scroll-off the clear sweep puts the character (a space for a newline) in cell 0
        o_res.cell0_word = {i_attr, is_nl ? CHAR_SPACE : i_char};
        o_res.wr_en      = !is_nl && !o_res.ovf;

        // Cursor after the item; a character that scrolls off lands in cell 0
        if (o_res.ovf) begin
            o_res.row_nx = '0;
            o_res.col_nx = is_nl ? COL_W'(0) : COL_W'(1);
        end else if (is_nl) begin
            o_res.row_nx = row_inc[ROW_W-1:0];
            o_res.col_nx = '0;
        end else if (is_bs) begin
            o_res.row_nx = row_w;
            o_res.col_nx = col_w;
        end else begin
            o_res.row_nx = row_w;
            o_res.col_nx = col_w + COL_W'(1);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/text_console_cursor_writer_unit.sv
// Top level of the text console cursor writer: handshakes, registers, sequencing.
`default_nettype none

// Text console with a write cursor over an 80 x 25 cell store (16-bit cells,
// attribute high byte, character low byte). A put transaction (tuser = 0)
// writes at the cursor, handling newline and backspace, and returns the new
// cursor at once; a new put is taken while the last result drains. A read
// transaction (tuser = 1) returns one cell via the store's registered read
// port and the ST_READ state. A result waits in an output register; input is
// taken when idle and that register is empty or being drained. After reset,
// and after a put runs past the last row, the store is swept to spaces one
// cell a cycle over all 2000 cells, taking no input (the APB port stays open).
// The put that scrolls off already reports the homed cursor: row 0, column 0
// after a newline, column 1 after a character, which the sweep leaves in cell 0.
module text_console_cursor_writer_unit
    import tccw_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,  // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire  [0:0]  i_s_axis_tuser,  // [0] action
    // Output stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [7:0] cell_char, [15:8] cell_attr,
                                         // [20:16] cursor_row, [27:21] cursor_col, [31:28] zero
    // APB configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [3:0]         r_fg;
    logic [3:0]         r_bg;
    logic [IDX_W-1:0]   r_clr_idx;
    t_cell_word         r_fill_word;
    t_cell_word         r_cell0_word;
    logic               r_rd_oor;
    logic               r_out_valid;
    logic [31:0]        r_out_data;

    logic [CHAR_W-1:0]  in_char;
    logic [IDX_W-1:0]   in_idx;
    logic               in_act;
    logic               in_acc;
    logic               put_acc;
    logic               rd_acc;
    logic               rd_in_range;
    logic [ATTR_W-1:0]  attr;
    t_put_res           put_res;
    logic               apb_wr;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_cell_word         mem_wdata;
    t_cell_word         mem_rdata;

    // Input field unpacking
    assign in_char = i_s_axis_tdata[7:0];
    assign in_idx  = i_s_axis_tdata[18:8];
    assign in_act  = i_s_axis_tuser[0];
    assign attr    = {r_bg, r_fg};

    // Take input only when idle and the output slot frees up
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign put_acc         = in_acc && (in_act == ACT_PUT);
    assign rd_acc          = in_acc && (in_act == ACT_READ);
    assign rd_in_range     = (in_idx < IDX_W'(CELLS));

    tccw_cursor u_cursor (
        .i_row  (r_row),
        .i_col  (r_col),
        .i_char (in_char),
        .i_attr (attr),
        .o_res  (put_res)
    );

    // Store write port: clear sweep or a put
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = (r_clr_idx == '0) ? r_cell0_word : r_fill_word;
        end else begin
            mem_we    = put_acc && put_res.wr_en;
            mem_waddr = put_res.wr_addr;
            mem_wdata = put_res.wr_word;
        end
    end

    tccw_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_acc && rd_in_range),
        .i_raddr (in_idx),
        .o_rdata (mem_rdata)
    );

    // APB register file
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BG) ? {28'd0, r_bg} : {28'd0, r_fg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= ATTR_RESET[3:0];
            r_bg <= ATTR_RESET[7:4];
        end else if (apb_wr) begin
            if (paddr[2] == REG_FG) begin
                r_fg <= pwdata[3:0];
            end else begin
                r_bg <= pwdata[3:0];
            end
        end
    end

    // Sequencer, cursor and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_row        <= '0;
            r_col        <= '0;
            r_clr_idx    <= '0;
            r_fill_word  <= {ATTR_RESET, CHAR_SPACE};
            r_cell0_word <= {ATTR_RESET, CHAR_SPACE};
            r_out_valid  <= 1'b0;
        end else begin
            // Drain, unless a put refills the slot in the same cycle
            if (r_out_valid && i_m_axis_tready && !put_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_idx == IDX_W'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                end
                ST_IDLE: begin
                    if (put_acc) begin
                        r_row       <= put_res.row_nx;
                        r_col       <= put_res.col_nx;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, put_res.col_nx, put_res.row_nx, 16'd0};
                        if (put_res.ovf) begin
                            r_state      <= ST_CLEAR;
                            r_clr_idx    <= '0;
                            r_fill_word  <= {attr, CHAR_SPACE};
                            r_cell0_word <= put_res.cell0_word;
                        end
                    end else if (rd_acc) begin
                        r_rd_oor <= !rd_in_range;
                        r_state  <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= {4'd0, r_col, r_row,
                                    r_rd_oor ? 16'd0 : mem_rdata};
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // No input is taken during the clear sweep
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_axis_tready)
        else $error("input taken during clear sweep");

    // A read transaction is followed by the read-data cycle
    a_read_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> (r_state == ST_READ))
        else $error("read transaction did not enter data cycle");

    // Scrolling off the last row homes the cursor and starts a sweep
    a_scroll_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_acc && put_res.ovf) |=>
            (r_state == ST_CLEAR) && (r_row == '0) && (r_col <= COL_W'(1)) &&
            (r_clr_idx == '0))
        else $error("scroll did not home cursor and clear");

    // Reported cursor stays on screen (column may sit at the wrap point)
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[20:16] < ROW_W'(ROWS)) &&
                        (r_out_data[27:21] <= COL_W'(COLUMNS)))
        else $error("cursor out of range");

endmodule

`default_nettype wire

>>> dv/tb_text_console_cursor_writer_unit.sv
// Self-checking testbench for the text console cursor writer: stream stimulus, APB colors, scoreboard.
`default_nettype none

module tb_text_console_cursor_writer_unit;
    import tccw_pkg::*;

    // Expected result, packed in the same bit order as the output tdata
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] ch;
    } t_console_result;

    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] char_code, [18:8] cell_index, [23:19] zero
    logic [0:0]  s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [7:0] cell_char, [15:8] cell_attr, [20:16] row, [27:21] col
    logic        apb_sel;
    logic        apb_enable;
    logic        apb_write;
    logic [2:0]  apb_addr;
    logic [31:0] apb_wdata;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    // Shadow copy of the console: screen, cursor and colors
    logic [CELL_W-1:0] shadow_screen [CELLS];
    int                cur_row;
    int                cur_col;
    logic [3:0]        fg_reg;
    logic [3:0]        bg_reg;

    t_console_result   pending_results [$];
    int                fail_count;
    bit                send_steady;   // sender never idles
    bit                recv_steady;   // receiver never idles
    bit                hold_req;      // receiver holds off for HOLD_CYCLES

    text_console_cursor_writer_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (apb_sel),
        .penable         (apb_enable),
        .pwrite          (apb_write),
        .paddr           (apb_addr),
        .pwdata          (apb_wdata),
        .prdata          (apb_rdata),
        .pready          (apb_ready)
    );

    always #5 clk = ~clk;

    // Console predictor
    function automatic void fill_screen(input logic [ATTR_W-1:0] attr);
        for (int i = 0; i < CELLS; i++) shadow_screen[i] = {attr, CHAR_SPACE};
    endfunction

    function automatic void advance_row(input logic [ATTR_W-1:0] attr);
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            // scrolled off the bottom: clear with the current colors, home
            fill_screen(attr);
            cur_row = 0;
            cur_col = 0;
        end
    endfunction

    function automatic t_console_result console_apply(input logic act,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [IDX_W-1:0] idx);
        t_console_result   res;
        logic [ATTR_W-1:0] attr;
        res  = '0;
        attr = {bg_reg, fg_reg};
        if (act == ACT_READ) begin
            if (idx < CELLS) begin
                res.ch   = shadow_screen[idx][CHAR_W-1:0];
                res.attr = shadow_screen[idx][CELL_W-1:CHAR_W];
            end
        end else if (ch == CHAR_NL) begin
            advance_row(attr);
        end else if (ch == CHAR_BS) begin
            if (cur_col > 0) cur_col--;
            shadow_screen[cur_row * COLUMNS + cur_col] = {attr, CHAR_SPACE};
        end else begin
            if (cur_col >= COLUMNS) advance_row(attr);
            shadow_screen[cur_row * COLUMNS + cur_col] = {attr, ch};
            cur_col++;
        end
        res.row = cur_row[ROW_W-1:0];
        res.col = cur_col[COL_W-1:0];
        return res;
    endfunction

    // Send one input transaction; predict at acceptance
    task automatic send_item(input logic act, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = 0;
        while (!send_steady && gap < 8 && $urandom_range(0, 99) < 33) gap++;
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, idx, ch};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(console_apply(act, ch, idx));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(ACT_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int idx);
        send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Drain results and let any screen sweep finish
    task automatic wait_idle();
        stop_sending();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // APB write: setup then access phase
    task automatic write_color(input logic sel, input logic [3:0] val);
        @(negedge clk);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {sel, 2'b00};
        apb_wdata  <= {28'($urandom), val};
        @(negedge clk);
        apb_enable <= 1'b1;
        @(posedge clk);
        while (!apb_ready) @(posedge clk);
        if (sel == REG_FG) fg_reg = val;
        else bg_reg = val;
        @(negedge clk);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        apb_write  <= 1'b0;
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        wait_idle();
        write_color(REG_FG, fg);
        write_color(REG_BG, bg);
    endtask

    // One random transaction, or a long printable run that reaches the wrap point
    task automatic random_item(inout int count);
        int pick;
        int run_len;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            run_len = $urandom_range(80, 90);
            repeat (run_len) put_char(CHAR_W'($urandom_range(8'h21, 8'h7E)));
            count += run_len;
        end else begin
            if (pick < 55) put_char(CHAR_W'($urandom_range(0, 255)));
            else if (pick < 63) put_char(CHAR_NL);
            else if (pick < 70) put_char(CHAR_BS);
            else if (pick < 90) read_cell(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            else read_cell($urandom_range(0, 2047));
            count++;
        end
    endtask

    task automatic random_run(input int n);
        int count;
        count = 0;
        while (count < n) random_item(count);
    endtask

    // Cleared store after reset, including out-of-range reads
    task automatic test_reset_contents();
        read_cell(0);
        read_cell(1);
        read_cell(1024);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
    endtask

    // Byte extremes, backspace mid-line and at column 0, newline
    task automatic test_put_and_erase();
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(CHAR_BS);
        put_char(CHAR_NL);
        put_char(CHAR_BS);
        put_char(8'h5A);
        put_char(CHAR_NL);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(3);
        read_cell(COLUMNS);
        read_cell(COLUMNS + 1);
    endtask

    // Attribute follows both color registers
    task automatic test_color_registers();
        set_colors(4'hF, 4'hF);
        put_char(8'h23);
        read_cell(cur_row * COLUMNS);
        set_colors(4'h0, 4'h0);
        put_char(8'h24);
        read_cell(cur_row * COLUMNS + 1);
    endtask

    // Random text under several color settings
    task automatic test_random_text();
        set_colors(4'h7, 4'h0);
        random_run(250);
        set_colors(4'hF, 4'hF);
        random_run(250);
        set_colors(4'h0, 4'h0);
        random_run(250);
        set_colors(4'($urandom), 4'($urandom));
        random_run(250);
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        wait_idle();
        send_steady = 1'b1;
        hold_req    = 1'b1;
        random_run(80);
        send_steady = 1'b0;
    endtask

    // Long stretch with no idling on either side
    task automatic test_steady_stream();
        wait_idle();
        send_steady = 1'b1;
        recv_steady = 1'b1;
        random_run(300);
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        t_console_result want;
        t_console_result got;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_console_result'(m_tdata[27:0]);
            if (pending_results.size() == 0) begin
                $error("result with no pending transaction: 0x%08h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("cell_char", want.ch, got.ch);
                compare_field("cell_attr", want.attr, got.attr);
                compare_field("cursor_row", want.row, got.row);
                compare_field("cursor_col", want.col, got.col);
            end
        end
    end

    // Receiver ready: random idling, steady stretches, long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                m_tready <= recv_steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        apb_sel     = 1'b0;
        apb_enable  = 1'b0;
        apb_write   = 1'b0;
        apb_addr    = '0;
        apb_wdata   = '0;
        fail_count  = 0;
        send_steady = 1'b0;
        recv_steady = 1'b0;
        hold_req    = 1'b0;
        fg_reg      = 4'h7;
        bg_reg      = 4'h0;
        cur_row     = 0;
        cur_col     = 0;
        fill_screen(ATTR_RESET);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_put_and_erase();
        test_color_registers();
        test_random_text();
        test_output_stall();
        test_steady_stream();

        stop_sending();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_mem.sv
hw/rtl/tccw_cursor.sv
hw/rtl/text_console_cursor_writer_unit.sv
dv/tb_text_console_cursor_writer_unit.sv
